// ----- design/assert_macros.svh -----
// Assertion macros for the adjacency_duplicate_check design file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same check, also enforced while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/adc_pkg.sv -----
// Types and constants for the adjacency duplicate checker.
// No dependencies; used by adjacency_duplicate_check.
package adc_pkg;

   localparam int unsigned VERTEX_COUNT = 1024;
   localparam int unsigned ADDR_W       = $clog2(VERTEX_COUNT);
   localparam int unsigned FIELD_W      = 10;
   localparam int unsigned STAMP_W      = 11;
   localparam int unsigned COUNT_W      = 2;
   localparam logic [COUNT_W-1:0] SELF_LOOP_LIMIT = 2'd2;
   localparam logic [COUNT_W-1:0] SELF_LOOP_SAT   = 2'd3;

   typedef enum logic [1:0] {
      STATUS_UNIQUE    = 2'd0,
      STATUS_REPEAT    = 2'd1,
      STATUS_SELF_LOOP = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] owner;
      logic [FIELD_W-1:0] neighbor;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       any_duplicate;
   } rsp_type;

   function automatic logic in_table_f(input logic [FIELD_W-1:0] neighbor);
      return 32'(neighbor) < VERTEX_COUNT;
   endfunction

endpackage

// ----- design/adc_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old data.
module adc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/adjacency_duplicate_check.sv -----
// Adjacency duplicate checker: stamp table in one RAM, read-modify-write per beat.
// Latency: a beat accepted on req passes through stage 1 and the output register before its result shows on rsp.
// Throughput: one beat per cycle while rsp is not stalled, set by the stamp RAM's one read and one write
// per cycle; a back-to-back hit on the same neighbor is forwarded.
// Reset: a clearing pass writes zero to all VERTEX_COUNT (1024) stamp entries,
// one per cycle; req_ready stays low until the pass ends.
`include "assert_macros.svh"

module adjacency_duplicate_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  adc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output adc_pkg::rsp_type rsp_data
);
   import adc_pkg::*;

   // control
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // stage 1: RAM data returning
   logic               s1_valid_ff, s1_valid_in;
   logic [FIELD_W-1:0] s1_owner_ff, s1_neighbor_ff;
   logic [STAMP_W-1:0] s1_tag_ff;
   logic               s1_in_table_ff;
   logic               s1_hit_ff;
   logic [STAMP_W-1:0] s1_hit_tag_ff;

   // per-owner state
   logic [STAMP_W-1:0] prev_tag_ff, prev_tag_in;
   logic [COUNT_W-1:0] loop_cnt_ff, loop_cnt_in;
   logic               dup_ff, dup_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff;

   logic               req_fire;
   logic               s1_advance;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [STAMP_W-1:0] ram_wr_data;
   logic [STAMP_W-1:0] ram_rd_data;
   logic [STAMP_W-1:0] stored_tag;
   logic               s1_is_self;
   logic [COUNT_W-1:0] cnt_base;
   status_type         s1_status;

   adc_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (VERTEX_COUNT)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ADDR_W'(req_data.neighbor)),
      .rd_data (ram_rd_data)
   );

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   // hold new reads while stage 1 stalls so its RAM data stays put
   assign req_ready  = (state_ff == ST_RUN) && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(s1_neighbor_ff);
      ram_wr_data = s1_tag_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(VERTEX_COUNT - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ram_wr_en = s1_advance && s1_in_table_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // stage 1 check
   always_comb begin
      stored_tag  = s1_hit_ff ? s1_hit_tag_ff : ram_rd_data;
      s1_is_self  = (s1_owner_ff == s1_neighbor_ff);
      cnt_base    = (s1_tag_ff != prev_tag_ff) ? '0 : loop_cnt_ff;
      loop_cnt_in = cnt_base;
      s1_status   = STATUS_UNIQUE;
      if (s1_is_self) begin
         if (cnt_base != SELF_LOOP_SAT) begin
            loop_cnt_in = cnt_base + 1'b1;
         end
         if (loop_cnt_in > SELF_LOOP_LIMIT) begin
            s1_status = STATUS_SELF_LOOP;
         end
      end else if (s1_in_table_ff && (stored_tag == s1_tag_ff)) begin
         s1_status = STATUS_REPEAT;
      end
      prev_tag_in  = s1_tag_ff;
      dup_in       = dup_ff || (s1_status != STATUS_UNIQUE);
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_tag_ff  <= '0;
         loop_cnt_ff  <= '0;
         dup_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance) begin
            prev_tag_ff <= prev_tag_in;
            loop_cnt_ff <= loop_cnt_in;
            dup_ff      <= dup_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_owner_ff    <= req_data.owner;
         s1_neighbor_ff <= req_data.neighbor;
         s1_tag_ff      <= STAMP_W'(req_data.owner) + 1'b1;
         s1_in_table_ff <= in_table_f(req_data.neighbor);
         // forward the stamp being written at this same edge
         s1_hit_ff      <= ram_wr_en && (state_ff == ST_RUN)
                           && (s1_neighbor_ff == req_data.neighbor);
         s1_hit_tag_ff  <= s1_tag_ff;
      end
      if (s1_advance) begin
         out_data_ff.status        <= s1_status;
         out_data_ff.any_duplicate <= dup_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `ASSERT_CLK(a_no_accept_in_clear, (state_ff == ST_CLEAR) |-> !req_ready, "beat accepted during clear")
   `ASSERT_CLK(a_rd_hold_on_stall, (s1_valid_ff && !s1_advance) |-> !req_fire, "RAM read while stage 1 stalled")
   `ASSERT_CLK(a_dup_sticky, dup_ff |=> dup_ff, "duplicate flag dropped")
   `ASSERT_CLK(a_self_status, (s1_advance && (s1_status == STATUS_SELF_LOOP)) |-> s1_is_self, "self-loop status on non-self entry")
   `ASSERT_ALWAYS(a_reset_clear, reset |=> (state_ff == ST_CLEAR) && !rsp_valid, "reset did not start clear")

endmodule

// ----- tb/adjacency_duplicate_check_tb.sv -----
// Self-checking testbench for adjacency_duplicate_check: streams adjacency entries,
// predicts status and the sticky duplicate flag, and compares every result beat.
// Depends on adc_pkg and the adjacency_duplicate_check RTL.
`timescale 1ns / 1ps

module adjacency_duplicate_check_tb;
   import adc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the checker state
   logic [STAMP_W-1:0] neighbor_stamps [VERTEX_COUNT];
   logic [STAMP_W-1:0] owner_tag;
   logic [COUNT_W-1:0] loop_count;
   logic               dup_flag;

   rsp_type status_backlog [$];
   bit      steady;
   int      cycles;
   int      failures;
   int      entries_sent;
   int      results_seen;
   int      repeat_hits;
   int      self_loop_hits;

   adjacency_duplicate_check uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, status_backlog.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   function automatic rsp_type predict_status(input req_type entry);
      logic [STAMP_W-1:0] tag;
      logic               in_range;
      rsp_type            r;
      tag      = STAMP_W'(entry.owner) + 1'b1;
      in_range = 32'(entry.neighbor) < VERTEX_COUNT;
      r.status = STATUS_UNIQUE;
      if (tag != owner_tag) begin
         loop_count = '0;
         owner_tag  = tag;
      end
      if (entry.neighbor == entry.owner) begin
         if (loop_count != SELF_LOOP_SAT)
            loop_count = loop_count + 1'b1;
         if (loop_count > SELF_LOOP_LIMIT)
            r.status = STATUS_SELF_LOOP;
      end else if (in_range && neighbor_stamps[entry.neighbor] == tag) begin
         r.status = STATUS_REPEAT;
      end
      if (in_range)
         neighbor_stamps[entry.neighbor] = tag;
      if (r.status != STATUS_UNIQUE)
         dup_flag = 1'b1;
      r.any_duplicate = dup_flag;
      return r;
   endfunction

   // Request beats are predicted before result beats of the same edge are checked.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            status_backlog.push_back(predict_status(req_data));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (status_backlog.size() == 0) begin
               $error("result beat with nothing expected: status %0d any_duplicate %0d",
                      rsp_data.status, rsp_data.any_duplicate);
               failures++;
            end else begin
               want = status_backlog.pop_front();
               if (want.status == STATUS_REPEAT)
                  repeat_hits++;
               if (want.status == STATUS_SELF_LOOP)
                  self_loop_hits++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.any_duplicate !== want.any_duplicate) begin
                  $error("any_duplicate: expected %0d, got %0d",
                         want.any_duplicate, rsp_data.any_duplicate);
                  failures++;
               end
            end
         end
      end
   end

   task automatic send_entry(input logic [FIELD_W-1:0] owner, input logic [FIELD_W-1:0] neighbor);
      req_type entry;
      int      gap;
      entry.owner    = owner;
      entry.neighbor = neighbor;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < 27)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= entry;
      do @(posedge clock); while (!req_ready);
      entries_sent++;
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (status_backlog.size() != 0);
   endtask

   task automatic test_field_extremes;
      send_entry(10'd0, 10'd0);
      send_entry(10'd0, 10'd1023);
      send_entry(10'd0, 10'd1);
      send_entry(10'd0, 10'd1023);
      send_entry(10'd1023, 10'd0);
      send_entry(10'd1023, 10'd1023);
      send_entry(10'd1023, 10'd0);
   endtask

   task automatic test_self_loops;
      // two entries per self-loop are normal, the third and later repeat
      repeat (4) send_entry(10'd5, 10'd5);
      send_entry(10'd5, 10'd6);
      send_entry(10'd5, 10'd5);
      send_entry(10'd6, 10'd6);
   endtask

   task automatic test_owner_order;
      // a return to an earlier owner can hit its stale stamps
      send_entry(10'd10, 10'd30);
      send_entry(10'd11, 10'd31);
      send_entry(10'd10, 10'd30);
      send_entry(10'd10, 10'd31);
      // an owner change clears the self-loop count
      send_entry(10'd12, 10'd12);
      send_entry(10'd12, 10'd12);
      send_entry(10'd13, 10'd13);
      send_entry(10'd12, 10'd12);
      send_entry(10'd12, 10'd12);
   endtask

   // One compressed-adjacency walk: nondecreasing owners, neighbors often from
   // a small pool so repeats are common, with bursts of self-loops.
   task automatic send_graph(input int stop_at);
      logic [FIELD_W-1:0] owner;
      logic [FIELD_W-1:0] pool_base;
      int                 owner_idx;
      int                 fanout;
      int                 pick;
      owner_idx = $urandom_range(0, VERTEX_COUNT - 1);
      pool_base = FIELD_W'($urandom_range(0, VERTEX_COUNT - 1));
      while (owner_idx < VERTEX_COUNT && entries_sent < stop_at) begin
         owner  = FIELD_W'(owner_idx);
         fanout = $urandom_range(0, 6);
         for (int k = 0; k < fanout && entries_sent < stop_at; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
               repeat ($urandom_range(1, 4)) send_entry(owner, owner);
            else if (pick < 65)
               send_entry(owner, pool_base + FIELD_W'($urandom_range(0, 15)));
            else
               send_entry(owner, FIELD_W'($urandom));
         end
         owner_idx += $urandom_range(1, 3);
      end
   endtask

   task automatic test_random_graphs(input int count);
      int stop_at;
      stop_at = entries_sent + count;
      while (entries_sent < stop_at)
         send_graph(stop_at);
   endtask

   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      test_random_graphs(count);
      steady = 1'b0;
   endtask

   // Unordered owners: fully random entries and jumps back to recent owners.
   task automatic test_broken_order(input int count);
      logic [FIELD_W-1:0] last_owner;
      logic [FIELD_W-1:0] owner;
      last_owner = '0;
      repeat (count) begin
         if ($urandom_range(0, 1)) begin
            owner = FIELD_W'($urandom);
            send_entry(owner, FIELD_W'($urandom));
         end else begin
            owner = last_owner - FIELD_W'($urandom_range(0, 3));
            send_entry(owner, last_owner + FIELD_W'($urandom_range(0, 7)));
         end
         last_owner = owner;
      end
   endtask

   initial begin
      for (int i = 0; i < VERTEX_COUNT; i++)
         neighbor_stamps[i] = '0;
      owner_tag  = '0;
      loop_count = '0;
      dup_flag   = 1'b0;
      steady     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_self_loops();
      test_owner_order();
      drain_results();
      test_random_graphs(700);
      drain_results();
      test_steady_stream(300);
      test_broken_order(300);
      drain_results();
      test_random_graphs(600);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d adjacency entries, checked %0d results in %0d cycles",
               entries_sent, results_seen, cycles);
      $display("Saw %0d repeated neighbors and %0d repeated self-loops",
               repeat_hits, self_loop_hits);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/adc_pkg.sv
design/adc_ram.sv
design/adjacency_duplicate_check.sv
tb/adjacency_duplicate_check_tb.sv
